// File: sv/ulbp_pkg.sv
`default_nettype none

package ulbp_pkg;

   // Elaboration defaults for the top-level parameters.
   localparam int MaxWidthDefault = 1024;
   localparam int RowBitsDefault  = 12;

   // Depth of the queue between the window front end and the classifier.
   localparam int QueueDepth = 4;

   // Configuration and coding constants.
   localparam int          CsrWidthBits    = 11;
   localparam logic [10:0] WidthReset      = 11'd640;
   localparam int          MinWidth        = 3;
   localparam logic [7:0]  NonuniformCode  = 8'd59;
   localparam logic [3:0]  UniformLimit    = 4'd2;

   // One accepted input beat.
   typedef struct packed {
      logic [7:0] pixel;
      logic       frame_start;
   } req_type;

   // One delivered result beat.
   typedef struct packed {
      logic [7:0]  lbp_code;
      logic        is_uniform;
      logic [9:0]  center_col;
      logic [11:0] center_row;
   } rsp_type;

   // Raw neighbor pattern with its position, as queued between front and back.
   typedef struct packed {
      logic [7:0]  pattern;
      logic [9:0]  center_col;
      logic [11:0] center_row;
   } entry_type;

   // Number of 0/1 changes around the circular 8-bit pattern.
   function automatic logic [3:0] count_transitions(logic [7:0] code);
      logic [7:0] diff;
      logic [3:0] n;
      diff = code ^ {code[6:0], code[7]};
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + 4'(diff[i]);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// File: sv/ulbp_front.sv
`default_nettype none

module ulbp_front #(
   parameter int MAX_WIDTH = ulbp_pkg::MaxWidthDefault,
   parameter int ROW_BITS  = ulbp_pkg::RowBitsDefault
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    accept,
   input  ulbp_pkg::req_type      req_data,
   input  wire                    csr_write,
   input  wire [10:0]             csr_data,
   output logic                   busy,
   output logic                   ent_push,
   output ulbp_pkg::entry_type    ent_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CW = (WW > ulbp_pkg::CsrWidthBits) ? WW : ulbp_pkg::CsrWidthBits;
   localparam logic [ROW_BITS-1:0] RowMax = {ROW_BITS{1'b1}};

   // Configuration, counters and window.
   logic [10:0]         width_ff;
   logic [AW-1:0]       col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [7:0]          win_ff [6];

   // Line buffers and their registered read data.
   logic [7:0] upper_mem  [MAX_WIDTH];
   logic [7:0] middle_mem [MAX_WIDTH];
   logic [7:0] rd_top_ff, rd_mid_ff;

   // Second stage: the beat whose buffer reads are now available.
   logic                s2_valid_ff;
   logic                s2_fire_ff;
   logic                s2_fwd_ff;
   logic [7:0]          s2_px_ff;
   logic [AW-1:0]       s2_col_ff;
   logic [ROW_BITS-1:0] s2_row_ff;

   logic [CW-1:0]       width_eff, csr_ext;
   logic [AW-1:0]       col_s, col_a;
   logic [ROW_BITS-1:0] row_s, row_a;
   logic                fire_a;
   logic [7:0]          top, mid, ctr;
   logic [7:0]          pattern;
   logic [AW-1:0]       col_m1;
   logic [ROW_BITS-1:0] row_m1;

   // Clamp the programmed width into the supported range.
   always_comb begin
      csr_ext = CW'(width_ff);
      if (csr_ext < CW'(ulbp_pkg::MinWidth)) begin
         width_eff = CW'(ulbp_pkg::MinWidth);
      end else if (csr_ext > CW'(MAX_WIDTH)) begin
         width_eff = CW'(MAX_WIDTH);
      end else begin
         width_eff = csr_ext;
      end
   end

   // Position of the incoming pixel and the position after it.
   always_comb begin
      col_s = req_data.frame_start ? '0 : col_ff;
      row_s = req_data.frame_start ? '0 : row_ff;
      col_a = col_s;
      row_a = row_s;
      if (CW'(col_s) >= width_eff) begin
         col_a = '0;
         row_a = (row_s != RowMax) ? row_s + 1'b1 : row_s;
      end
      if (CW'(col_a) + CW'(1) >= width_eff) begin
         col_in = '0;
         row_in = (row_a != RowMax) ? row_a + 1'b1 : row_a;
      end else begin
         col_in = col_a + 1'b1;
         row_in = row_a;
      end
      fire_a = (row_a >= ROW_BITS'(2)) && (col_a >= AW'(2));
   end

   // Configuration register; the port is always ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= ulbp_pkg::WidthReset;
      end else if (csr_write) begin
         width_ff <= csr_data;
      end
   end

   // Column and row counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Middle line buffer: read the old entry and store the new pixel at once.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_mid_ff          <= middle_mem[col_a];
         middle_mem[col_a]  <= req_data.pixel;
      end
   end

   // Upper line buffer: read on accept, written from the second stage with the old middle entry.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_top_ff <= upper_mem[col_a];
      end
      if (s2_valid_ff) begin
         upper_mem[s2_col_ff] <= rd_mid_ff;
      end
   end

   // Second-stage control and payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s2_fire_ff <= fire_a;
         // Same column as the beat being retired: its upper write lands too late.
         s2_fwd_ff  <= s2_valid_ff && (col_a == s2_col_ff);
         s2_px_ff   <= req_data.pixel;
         s2_col_ff  <= col_a;
         s2_row_ff  <= row_a;
      end
   end

   // Neighbors of the center and the raw pattern, MSB first.
   always_comb begin
      top = s2_fwd_ff ? win_ff[3] : rd_top_ff;
      mid = rd_mid_ff;
      ctr = win_ff[3];
      pattern[7] = win_ff[0] > ctr;
      pattern[6] = win_ff[2] > ctr;
      pattern[5] = win_ff[4] > ctr;
      pattern[4] = win_ff[5] > ctr;
      pattern[3] = s2_px_ff  > ctr;
      pattern[2] = mid       > ctr;
      pattern[1] = top       > ctr;
      pattern[0] = win_ff[1] > ctr;
   end

   // Window shift, one column per retired beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= 8'd0;
         end
      end else if (s2_valid_ff) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= top;
         win_ff[2] <= win_ff[3];
         win_ff[3] <= mid;
         win_ff[4] <= win_ff[5];
         win_ff[5] <= s2_px_ff;
      end
   end

   // Hand the pattern to the queue for interior centers only.
   always_comb begin
      col_m1              = s2_col_ff - 1'b1;
      row_m1              = s2_row_ff - 1'b1;
      busy                = s2_valid_ff;
      ent_push            = s2_valid_ff && s2_fire_ff;
      ent_data.pattern    = pattern;
      ent_data.center_col = 10'(col_m1);
      ent_data.center_row = 12'(row_m1);
   end

endmodule

`default_nettype wire

// File: sv/ulbp_queue.sv
`default_nettype none

module ulbp_queue #(
   parameter int DEPTH = ulbp_pkg::QueueDepth
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   input  ulbp_pkg::entry_type          push_data,
   input  wire                          pop,
   output logic                         nonempty,
   output ulbp_pkg::entry_type          head,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   ulbp_pkg::entry_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0] count_ff;

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign nonempty = (count_ff != '0);
   assign head     = mem_ff[rd_ptr_ff];
   assign count    = count_ff;

endmodule

`default_nettype wire

// File: sv/ulbp_back.sv
`default_nettype none

module ulbp_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  q_nonempty,
   input  ulbp_pkg::entry_type  q_head,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  wire                  rsp_pop,
   output ulbp_pkg::rsp_type    rsp_data
);

   logic                out_valid_ff;
   ulbp_pkg::rsp_type   out_ff, out_in;
   logic                uniform;

   // Classify the head pattern by its circular transitions.
   always_comb begin
      uniform           = ulbp_pkg::count_transitions(q_head.pattern) <= ulbp_pkg::UniformLimit;
      out_in.lbp_code   = uniform ? q_head.pattern : ulbp_pkg::NonuniformCode;
      out_in.is_uniform = uniform;
      out_in.center_col = q_head.center_col;
      out_in.center_row = q_head.center_row;
   end

   // Refill the output register whenever it is free or being taken.
   assign q_pop = q_nonempty && (!out_valid_ff || rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (q_pop) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_ff <= out_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

// File: sv/uniform_lbp_texture_filter.sv
// Uniform 3x3 local binary pattern filter over a raster stream of 8-bit pixels.
// Input: push a pixel beat on req_push while req_full is low; req_data.frame_start
// marks the first pixel of an image. Output: while rsp_empty is low, rsp_data holds
// the oldest result beat; raise rsp_pop to take it. Each interior center gives one
// beat; the first two rows and columns of input produce none.
// Configuration: csr_data is the row width, written on csr_valid (csr_ready is
// always high); write it only while no pixels are in flight.
// Throughput: one pixel per cycle, sustained while the receiver keeps popping.
// A result passes the buffer read at the edge that accepts its pixel, then the
// queue write and then the classifier output register; a receiver stall holds it
// in the queue.
// A four-entry queue between the pattern stage and the classifier absorbs receiver
// stalls; req_full rises once the queue plus the beat in the pattern stage would
// fill it, and no beat is dropped.
// Reset clears the counters, the window, the queue and the output register and sets
// the width to 640. Line buffers are not cleared; they refill before being read.

`default_nettype none

module uniform_lbp_texture_filter #(
   parameter int MAX_WIDTH = ulbp_pkg::MaxWidthDefault,
   parameter int ROW_BITS  = ulbp_pkg::RowBitsDefault
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_push,
   output logic                 req_full,
   input  ulbp_pkg::req_type    req_data,
   output logic                 rsp_empty,
   input  wire                  rsp_pop,
   output ulbp_pkg::rsp_type    rsp_data,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire [10:0]           csr_data
);

   localparam int QCW = $clog2(ulbp_pkg::QueueDepth + 1);

   logic                 accept;
   logic                 busy;
   logic                 ent_push;
   ulbp_pkg::entry_type  ent_data;
   logic                 q_pop, q_nonempty;
   ulbp_pkg::entry_type  q_head;
   logic [QCW-1:0]       q_count;
   logic [QCW:0]         occupancy;

   // Reserve queue room for every beat still in the pattern stage.
   assign occupancy = (QCW + 1)'(q_count) + (QCW + 1)'(busy);
   assign req_full  = occupancy >= (QCW + 1)'(ulbp_pkg::QueueDepth);
   assign accept    = req_push && !req_full;
   assign csr_ready = 1'b1;

   ulbp_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .ROW_BITS  (ROW_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .busy      (busy),
      .ent_push  (ent_push),
      .ent_data  (ent_data)
   );

   ulbp_queue #(
      .DEPTH (ulbp_pkg::QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ent_push),
      .push_data (ent_data),
      .pop       (q_pop),
      .nonempty  (q_nonempty),
      .head      (q_head),
      .count     (q_count)
   );

   ulbp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_nonempty (q_nonempty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

   // The pattern stage never pushes into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      ent_push |-> (q_count != QCW'(ulbp_pkg::QueueDepth)))
      else $error("pattern pushed into a full queue");

   // A non-uniform result always carries the catch-all code.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.is_uniform) |-> (rsp_data.lbp_code == ulbp_pkg::NonuniformCode))
      else $error("non-uniform result with a pattern code");

   // Nothing is offered right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("result offered right after reset");

   // A popped result is replaced only by a queued one.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !q_nonempty) |=> rsp_empty)
      else $error("output register refilled without a queued pattern");

endmodule

`default_nettype wire

// File: test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          MaxSpan       = ulbp_pkg::MaxWidthDefault;
   localparam int          RowCeiling    = (1 << ulbp_pkg::RowBitsDefault) - 1;
   localparam logic [7:0]  MixedCode     = 8'd59;
   localparam int          MaxChanges    = 2;
   localparam int          PhaseBeats    = 365;
   localparam int          ReportLimit   = 20;

   typedef enum {FILL_NOISE, FILL_LOW, FILL_BINARY} fill_type;

   // One row of the directed table; pinned rows carry a hand-written result.
   typedef struct {
      logic [7:0]  px;
      logic        fs;
      logic        pin;
      logic [7:0]  code;
      logic        uni;
      logic [9:0]  col;
      logic [11:0] row;
   } stim_row_type;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_push  = 1'b0;
   logic              req_full;
   ulbp_pkg::req_type req_data  = '0;
   logic              rsp_empty;
   logic              rsp_pop   = 1'b0;
   ulbp_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [10:0]       csr_data  = '0;

   // Hand-written expectation that travels with the pixel beat.
   logic              pinned_valid = 1'b0;
   ulbp_pkg::rsp_type pinned_rsp   = '0;

   int push_gap_pct  = 14;
   int pop_stall_pct = 49;
   int frame_span    = 640;

   // Predictor state: two stored rows, the 3x2 window and the raster position.
   logic [7:0]  prev2_row [MaxSpan] = '{default: '0};
   logic [7:0]  prev1_row [MaxSpan] = '{default: '0};
   logic [7:0]  top_l, top_c, mid_l, mid_c, bot_l, bot_c;
   int          cur_col, cur_row;
   logic [10:0] width_reg;

   ulbp_pkg::rsp_type pending_codes [$];
   int      error_count  = 0;
   int      pixels_seen  = 0;
   int      codes_seen   = 0;
   int      uniform_seen = 0;
   int      width_writes = 0;

   // Directed table: a 3-wide frame with equal, rising and mixed neighbors,
   // then a fresh frame whose center is below all eight neighbors.
   stim_row_type demo_rows [24] = '{
      '{8'd0,   1'b1, 1'b0, 8'd0,   1'b0, 10'd0, 12'd0},
      '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 10'd0, 12'd0},
      '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 10'd0, 12'd0},
      '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 10'd0, 12'd0},
      '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 10'd0, 12'd0},
      '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 10'd0, 12'd0},
      '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0, 10'd0, 12'd0},
      '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0, 10'd0, 12'd0},
      '{8'd255, 1'b0, 1'b1, 8'd56,  1'b1, 10'd1, 12'd1},
      '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0, 10'd0, 12'd0},
      '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 10'd0, 12'd0},
      '{8'd255, 1'b0, 1'b1, 8'd0,   1'b1, 10'd1, 12'd2},
      '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 10'd0, 12'd0},
      '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0, 10'd0, 12'd0},
      '{8'd0,   1'b0, 1'b1, 8'd59,  1'b0, 10'd1, 12'd3},
      '{8'd255, 1'b1, 1'b0, 8'd0,   1'b0, 10'd0, 12'd0},
      '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0, 10'd0, 12'd0},
      '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0, 10'd0, 12'd0},
      '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0, 10'd0, 12'd0},
      '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0, 10'd0, 12'd0},
      '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0, 10'd0, 12'd0},
      '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0, 10'd0, 12'd0},
      '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0, 10'd0, 12'd0},
      '{8'd255, 1'b0, 1'b1, 8'd255, 1'b1, 10'd1, 12'd1}
   };

   uniform_lbp_texture_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Free-running clock, 4 ns period.
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Advance the window by one pixel and report the code, if any, it completes.
   function automatic bit lbp_window_step(input ulbp_pkg::req_type beat,
                                          output ulbp_pkg::rsp_type res);
      int         span;
      logic [7:0] up, mid, pat;
      bit         hit;
      span = (width_reg < 11'd3) ? 3 : (width_reg > 11'(MaxSpan)) ? MaxSpan : int'(width_reg);
      res = '0;
      hit = 1'b0;
      if (beat.frame_start) begin
         cur_col = 0;
         cur_row = 0;
      end
      if (cur_col >= span) begin
         cur_col = 0;
         if (cur_row < RowCeiling) cur_row++;
      end
      up  = prev2_row[cur_col];
      mid = prev1_row[cur_col];

      // Neighbors strictly above the center set a bit, counter-clockwise from top-left.
      if (cur_row >= 2 && cur_col >= 2) begin
         pat = {top_l > mid_c, mid_l > mid_c, bot_l > mid_c, bot_c > mid_c,
                beat.pixel > mid_c, mid > mid_c, up > mid_c, top_c > mid_c};
         hit = 1'b1;
         res.is_uniform = ($countones(pat ^ {pat[6:0], pat[7]}) <= MaxChanges);
         res.lbp_code   = res.is_uniform ? pat : MixedCode;
         res.center_col = 10'(cur_col - 1);
         res.center_row = 12'(cur_row - 1);
      end

      top_l = top_c;
      top_c = up;
      mid_l = mid_c;
      mid_c = mid;
      bot_l = bot_c;
      bot_c = beat.pixel;
      prev2_row[cur_col] = mid;
      prev1_row[cur_col] = beat.pixel;

      cur_col++;
      if (cur_col >= span) begin
         cur_col = 0;
         if (cur_row < RowCeiling) cur_row++;
      end
      return hit;
   endfunction

   task automatic check_field(input string label, input logic [11:0] want,
                              input logic [11:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= ReportLimit)
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
      end
   endtask

   // Receiver: pop at random according to the current stall rate.
   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   // Observe every handshake: check results first, then track config and pixels.
   always @(posedge clock) begin
      ulbp_pkg::rsp_type want;
      bit                hit;
      if (reset) begin
         width_reg = ulbp_pkg::WidthReset;
         cur_col   = 0;
         cur_row   = 0;
         {top_l, top_c, mid_l, mid_c, bot_l, bot_c} = '0;
      end else begin
         if (!rsp_empty && rsp_pop) begin
            if (pending_codes.size() == 0) begin
               error_count++;
               if (error_count <= ReportLimit)
                  $display("%0t: expected no result, got %p", $time, rsp_data);
            end else begin
               want = pending_codes.pop_front();
               check_field("lbp_code", 12'(want.lbp_code), 12'(rsp_data.lbp_code));
               check_field("is_uniform", 12'(want.is_uniform), 12'(rsp_data.is_uniform));
               check_field("center_col", 12'(want.center_col), 12'(rsp_data.center_col));
               check_field("center_row", want.center_row, rsp_data.center_row);
               codes_seen++;
               if (rsp_data.is_uniform) uniform_seen++;
            end
         end
         if (csr_valid && csr_ready) begin
            width_reg = csr_data;
            width_writes++;
         end
         if (req_push && !req_full) begin
            pixels_seen++;
            hit = lbp_window_step(req_data, want);
            if (hit) begin
               if (pinned_valid) want = pinned_rsp;
               pending_codes.insert(pending_codes.size(), want);
            end
         end
      end
   end

   // Offer one pixel beat, with a random gap first, and hold it until taken.
   task automatic push_pixel(input logic [7:0] px, input logic fs, input logic pin,
                             input ulbp_pkg::rsp_type pin_rsp);
      while ($urandom_range(99) < push_gap_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push     <= 1'b1;
      req_data     <= '{pixel: px, frame_start: fs};
      pinned_valid <= pin;
      pinned_rsp   <= pin_rsp;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   // Stop pushing and wait until every expected code has been taken.
   task automatic settle();
      req_push <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_width(input logic [10:0] w);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      frame_span = (w < 11'd3) ? 3 : (w > 11'(MaxSpan)) ? MaxSpan : int'(w);
   endtask

   // Send a frame of the given length; restarts optionally break it midway.
   task automatic stream_pixels(input int count, input fill_type fill, input bit restarts);
      logic [7:0] px;
      logic       fs;
      for (int i = 0; i < count; i++) begin
         fs = (i == 0) || (restarts && $urandom_range(149) == 0);
         case (fill)
            FILL_LOW: begin
               px = 8'($urandom_range(3));
            end
            FILL_BINARY: begin
               px = $urandom_range(1) ? 8'd255 : 8'd0;
            end
            default: begin
               px = 8'($urandom_range(255));
            end
         endcase
         push_pixel(px, fs, 1'b0, '0);
      end
   endtask

   // Main sequence.
   initial begin
      ulbp_pkg::rsp_type pin;
      int                sent;
      logic [10:0]       w;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table at the narrowest legal width.
      set_width(11'd3);
      foreach (demo_rows[i]) begin
         pin = '{lbp_code: demo_rows[i].code, is_uniform: demo_rows[i].uni,
                 center_col: demo_rows[i].col, center_row: demo_rows[i].row};
         push_pixel(demo_rows[i].px, demo_rows[i].fs, demo_rows[i].pin, pin);
      end

      // Random frames under three idle profiles.
      for (int phase = 0; phase < 3; phase++) begin
         push_gap_pct  = (phase == 0) ? 14 : (phase == 1) ? 49 : 0;
         pop_stall_pct = (phase == 0) ? 49 : (phase == 1) ? 14 : 0;
         sent = 0;
         while (sent < PhaseBeats) begin
            if (sent == 0 || $urandom_range(1)) begin
               case ($urandom_range(7))
                  0: w = 11'($urandom_range(2));
                  1: w = 11'($urandom_range(17, 64));
                  default: w = 11'($urandom_range(3, 16));
               endcase
               set_width(w);
            end
            w = 11'($urandom_range(3, 7) * frame_span + $urandom_range(frame_span - 1));
            if (int'(w) > PhaseBeats - sent) w = 11'(PhaseBeats - sent);
            stream_pixels(int'(w), fill_type'($urandom_range(2)), $urandom_range(3) == 0);
            sent += int'(w);
         end
      end

      // Undersized widths act as three.
      set_width(11'd0);
      stream_pixels(12, FILL_NOISE, 1'b0);
      set_width(11'd2);
      stream_pixels(15, FILL_BINARY, 1'b0);

      settle();
      if (pending_codes.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected codes never arrived", $time, pending_codes.size());
      end
      $display("Covered %0d pixels and %0d codes (%0d uniform) over %0d width writes,",
               pixels_seen, codes_seen, uniform_seen, width_writes);
      $display("including directed 3-wide frames, random widths up to 64 and clamped widths.");
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog for a stuck handshake.
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
